@@ rtl/mscp_pkg.sv @@
package mscp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CENTER_RE  = 3'd0;
    localparam logic [2:0] CFG_CENTER_IM  = 3'd1;
    localparam logic [2:0] CFG_PIXEL_STEP = 3'd2;
    localparam logic [2:0] CFG_START_ITER = 3'd3;
    localparam logic [2:0] CFG_END_ITER   = 3'd4;
    localparam logic [2:0] CFG_MAX_ITER   = 3'd5;
    localparam logic [2:0] CFG_COLOR_EXP  = 3'd6;

    localparam logic [63:0] ESCAPE_LIMIT = 64'd10000000000;

    // Point coordinate handed from the front end to the orbit engine.
    typedef struct packed {
        logic [127:0] cr;
        logic [127:0] ci;
    } t_coord;

    // Outcome of one orbit.
    typedef struct packed {
        logic         escaped;
        logic [15:0]  iter;
        logic [127:0] sq;
    } t_orbit;

    // log2 of a nonzero integer with 32 fraction bits, for elaboration-time constants.
    function automatic logic [38:0] lg2_const(input logic [63:0] x);
        logic [6:0]  p;
        logic [63:0] m;
        logic [31:0] frac;
        p    = 7'd0;
        frac = 32'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = 7'(i);
            end
        end
        if (p >= 7'd31) begin
            m = x >> (p - 7'd31);
        end else begin
            m = x << (7'd31 - p);
        end
        m = m & 64'hFFFF_FFFF;
        for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m[32]) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return {p, frac};
    endfunction

    function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Successive square roots of two in Q2.30; entry k sits at bits 32*k.
    function automatic logic [1023:0] build_roots();
        logic [1023:0] tab;
        logic [63:0]   root;
        tab  = '0;
        root = 64'd2 << 30;
        for (int k = 31; k >= 0; k--) begin
            root = isqrt_const(root << 30);
            tab[k*32 +: 32] = root[31:0];
        end
        return tab;
    endfunction

    localparam logic [1023:0] ROOT_TAB = build_roots();
    localparam logic [38:0]   LG_LC    = lg2_const(ESCAPE_LIMIT);
    localparam logic [38:0]   LG_LC2   = lg2_const({25'd0, LG_LC});

endpackage

@@ rtl/mandelbrot_smooth_color_pixel_top.sv @@
// Channel    Dir  Fields (lowest bit first)
// s_*        in   tdata: offset_x[11:0], offset_y[23:12]
// m_*        out  tdata: red[7:0], green[15:8], blue[23:16]; tuser: escaped
// i_cfg_*    in   write enable, register index, 64-bit write data
//
// One pixel passes three front-end states (accept, multiply, push), and each orbit pass
// forms three 96 by 96 bit products as nine partial products on one shared 32 by 32
// multiplier, plus limit test, sum, compare and update.
// An escaped point then goes through up to three logarithms, a 50-step division and
// three powers of two built from a table of square roots of two; an inside point
// skips these and goes straight to the output stage of the color unit.
// Reset is synchronous and active low and clears all control state; no memory sweep.
// A two-word queue parts the front end from the orbit engine, and the result word is
// held in an output register so that a stalled sink does not stop work in progress.
module mandelbrot_smooth_color_pixel_top
    import mscp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // offset_x[11:0], offset_y[23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // red[7:0], green[15:8], blue[23:16]
    output logic        m_tuser,    // escaped
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers.
    logic [63:0] r_center_re;
    logic [63:0] r_center_im;
    logic [62:0] r_pixel_step;
    logic [15:0] r_start_iter;
    logic [15:0] r_end_iter;
    logic [15:0] r_max_iter;
    logic [47:0] r_color_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re  <= '0;
            r_center_im  <= '0;
            r_pixel_step <= '0;
            r_start_iter <= '0;
            r_end_iter   <= 16'd256;
            r_max_iter   <= 16'd256;
            r_color_exp  <= 48'd68723691520;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_RE:  r_center_re  <= i_cfg_data;
                CFG_CENTER_IM:  r_center_im  <= i_cfg_data;
                CFG_PIXEL_STEP: r_pixel_step <= i_cfg_data[62:0];
                CFG_START_ITER: r_start_iter <= i_cfg_data[15:0];
                CFG_END_ITER:   r_end_iter   <= i_cfg_data[15:0];
                CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[15:0];
                CFG_COLOR_EXP:  r_color_exp  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    logic   w_push;
    logic   w_push_ready;
    t_coord w_push_data;
    logic   w_q_valid;
    logic   w_pop;
    t_coord w_q_data;
    logic   w_orb_valid;
    logic   w_orb_ready;
    t_orbit w_orb;

    // The front end maps the pixel offset onto the complex plane.
    mscp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_data       (s_tdata),
        .i_center_re  (r_center_re),
        .i_center_im  (r_center_im),
        .i_pixel_step (r_pixel_step),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_coord      (w_push_data)
    );

    mscp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_data       (w_push_data),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_data       (w_q_data)
    );

    // The orbit engine iterates z = z*z + c until escape or the pass limit.
    mscp_orbit #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_orbit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_pop      (w_pop),
        .i_coord    (w_q_data),
        .i_max_iter (r_max_iter),
        .o_valid    (w_orb_valid),
        .i_ready    (w_orb_ready),
        .o_res      (w_orb)
    );

    // The color unit forms the smooth count, normalizes it and applies the gamma curves.
    mscp_color #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_orb_valid),
        .o_ready      (w_orb_ready),
        .i_res        (w_orb),
        .i_start_iter (r_start_iter),
        .i_end_iter   (r_end_iter),
        .i_color_exp  (r_color_exp),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_rgb        (m_tdata),
        .o_escaped    (m_tuser)
    );

endmodule

@@ rtl/mscp_front.sv @@
module mscp_front
    import mscp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [23:0]  i_data,
    input  logic [63:0]  i_center_re,
    input  logic [63:0]  i_center_im,
    input  logic [62:0]  i_pixel_step,
    output logic         o_push,
    input  logic         i_push_ready,
    output t_coord       o_coord
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} t_state;

    t_state       r_state;
    logic [11:0]  r_mag_x;
    logic [11:0]  r_mag_y;
    logic         r_neg_x;
    logic         r_neg_y;
    logic [74:0]  r_px;
    logic [74:0]  r_py;
    logic [127:0] w_dx;
    logic [127:0] w_dy;

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_ADD);

    assign w_dx = r_neg_x ? (128'd0 - {53'd0, r_px}) : {53'd0, r_px};
    assign w_dy = r_neg_y ? (128'd0 - {53'd0, r_py}) : {53'd0, r_py};
    assign o_coord.cr = {{64{i_center_re[63]}}, i_center_re} + w_dx;
    assign o_coord.ci = {{64{i_center_im[63]}}, i_center_im} + w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg_x <= i_data[11];
                        r_neg_y <= i_data[23];
                        r_mag_x <= i_data[11] ? (12'd0 - i_data[11:0]) : i_data[11:0];
                        r_mag_y <= i_data[23] ? (12'd0 - i_data[23:12]) : i_data[23:12];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_px    <= 75'(r_mag_x) * 75'(i_pixel_step);
                    r_py    <= 75'(r_mag_y) * 75'(i_pixel_step);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/mscp_queue.sv @@
module mscp_queue
    import mscp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_coord i_data,
    output logic   o_valid,
    input  logic   i_pop,
    output t_coord o_data
);

    t_coord     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_data       = r_mem[r_rp];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ rtl/mscp_orbit.sv @@
module mscp_orbit
    import mscp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_pop,
    input  t_coord      i_coord,
    input  logic [15:0] i_max_iter,
    output logic        o_valid,
    input  logic        i_ready,
    output t_orbit      o_res
);

    localparam int            F   = COORD_FRAC_BITS;
    localparam logic [127:0]  THR = 128'(ESCAPE_LIMIT) << F;

    typedef enum logic [2:0] {S_IDLE, S_LIM, S_MUL, S_SUM, S_CMP, S_UPD, S_DONE} t_state;

    t_state       r_state;
    logic [127:0] r_cr;
    logic [127:0] r_ci;
    logic [127:0] r_zr;
    logic [127:0] r_zi;
    logic [127:0] r_r2;
    logic [127:0] r_i2;
    logic [127:0] r_x;
    logic [127:0] r_sq;
    logic [95:0]  r_ar;
    logic [95:0]  r_ai;
    logic         r_sd;
    logic [15:0]  r_it;
    logic [1:0]   r_sel;
    logic [3:0]   r_step;
    logic [1:0]   r_wi;
    logic [1:0]   r_wj;
    logic [2:0]   r_msh;
    logic [63:0]  r_mul;
    logic [191:0] r_acc;
    logic         r_esc;

    logic [127:0] w_abs_r;
    logic [127:0] w_abs_i;
    logic [95:0]  w_opa;
    logic [95:0]  w_opb;
    logic [31:0]  w_wa;
    logic [31:0]  w_wb;
    logic [127:0] w_x2;

    assign w_abs_r = r_zr[127] ? (128'd0 - r_zr) : r_zr;
    assign w_abs_i = r_zi[127] ? (128'd0 - r_zi) : r_zi;
    assign w_x2    = {r_x[126:0], 1'b0};

    always_comb begin
        case (r_sel)
            2'd0:    begin w_opa = r_ar; w_opb = r_ar; end
            2'd1:    begin w_opa = r_ai; w_opb = r_ai; end
            default: begin w_opa = r_ar; w_opb = r_ai; end
        endcase
        case (r_wi)
            2'd0:    w_wa = w_opa[31:0];
            2'd1:    w_wa = w_opa[63:32];
            default: w_wa = w_opa[95:64];
        endcase
        case (r_wj)
            2'd0:    w_wb = w_opb[31:0];
            2'd1:    w_wb = w_opb[63:32];
            default: w_wb = w_opb[95:64];
        endcase
    end

    assign o_pop         = (r_state == S_IDLE) && i_valid;
    assign o_valid       = (r_state == S_DONE);
    assign o_res.escaped = r_esc;
    assign o_res.iter    = r_it;
    assign o_res.sq      = r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cr    <= i_coord.cr;
                        r_ci    <= i_coord.ci;
                        r_zr    <= '0;
                        r_zi    <= '0;
                        r_it    <= '0;
                        r_state <= S_LIM;
                    end
                end
                S_LIM: begin
                    if (r_it == i_max_iter) begin
                        r_esc   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_ar    <= w_abs_r[95:0];
                        r_ai    <= w_abs_i[95:0];
                        r_sd    <= r_zr[127] ^ r_zi[127];
                        r_sel   <= 2'd0;
                        r_step  <= 4'd0;
                        r_wi    <= 2'd0;
                        r_wj    <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step <= 4'd8) begin
                        r_mul <= 64'(w_wa) * 64'(w_wb);
                        r_msh <= {1'b0, r_wi} + {1'b0, r_wj};
                        if (r_wj == 2'd2) begin
                            r_wj <= 2'd0;
                            r_wi <= r_wi + 2'd1;
                        end else begin
                            r_wj <= r_wj + 2'd1;
                        end
                    end
                    if (r_step >= 4'd1 && r_step <= 4'd9) begin
                        r_acc <= r_acc + (192'(r_mul) << {r_msh, 5'd0});
                    end
                    if (r_step == 4'd10) begin
                        r_step <= 4'd0;
                        r_wi   <= 2'd0;
                        r_wj   <= 2'd0;
                        r_acc  <= '0;
                        case (r_sel)
                            2'd0: begin
                                r_r2  <= r_acc[F+127:F];
                                r_sel <= 2'd1;
                            end
                            2'd1: begin
                                r_i2    <= r_acc[F+127:F];
                                r_state <= S_SUM;
                            end
                            default: begin
                                r_x     <= r_acc[F+127:F];
                                r_state <= S_UPD;
                            end
                        endcase
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_SUM: begin
                    r_sq    <= r_r2 + r_i2;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_sq >= THR) begin
                        r_esc   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_sel   <= 2'd2;
                        r_state <= S_MUL;
                    end
                end
                S_UPD: begin
                    r_zr    <= r_r2 - r_i2 + r_cr;
                    r_zi    <= (r_sd ? (128'd0 - w_x2) : w_x2) + r_ci;
                    r_it    <= r_it + 16'd1;
                    r_state <= S_LIM;
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/mscp_color.sv @@
module mscp_color
    import mscp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_orbit      i_res,
    input  logic [15:0] i_start_iter,
    input  logic [15:0] i_end_iter,
    input  logic [47:0] i_color_exp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_rgb,
    output logic        o_escaped
);

    localparam logic [38:0] F_OFS = 39'(COORD_FRAC_BITS) << 32;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LSQ, S_LADJ, S_LDONE, S_T, S_DIV, S_TCHK,
        S_CH, S_CH2, S_EXP, S_EXPA, S_CHV, S_OUT
    } t_state;

    t_state       r_state;
    logic [15:0]  r_it;
    logic [127:0] r_lx;
    logic [6:0]   r_lp;
    logic [31:0]  r_m;
    logic [31:0]  r_frac;
    logic [4:0]   r_k;
    logic [1:0]   r_call;
    logic [38:0]  r_lt;
    logic [63:0]  r_mul;
    logic [51:0]  r_num;
    logic [49:0]  r_q;
    logic [16:0]  r_rem;
    logic [16:0]  r_ad;
    logic [5:0]   r_dcnt;
    logic [32:0]  r_t;
    logic [1:0]   r_ch;
    logic [53:0]  r_prod;
    logic [31:0]  r_g;
    logic [31:0]  r_acc;
    logic [4:0]   r_sh;
    logic [31:0]  r_v;
    logic [7:0]   r_chan [3];
    logic [23:0]  r_rgb;
    logic         r_esc;
    logic         r_pend_esc;
    logic         r_ovalid;

    logic [38:0]  w_lres;
    logic [16:0]  w_d;
    logic [51:0]  w_anum;
    logic [17:0]  w_tmp;
    logic [15:0]  w_e;
    logic [37:0]  w_negl;
    logic [41:0]  w_m;
    logic [9:0]   w_n;
    logic [31:0]  w_f;
    logic [31:0]  w_acc_new;
    logic [39:0]  w_v255;

    assign w_lres    = {r_lp, r_frac};
    assign w_d       = {1'b0, i_end_iter} - {1'b0, i_start_iter};
    assign w_anum    = r_num[51] ? (52'd0 - r_num) : r_num;
    assign w_tmp     = {r_rem, r_q[49]};
    assign w_negl    = (38'd32 << 32) - r_lt[37:0];
    assign w_m       = r_prod[53:12];
    assign w_n       = w_m[41:32];
    assign w_f       = w_m[31:0];
    assign w_acc_new = r_g[r_k] ? r_mul[61:30] : r_acc;
    assign w_v255    = ({8'd0, r_v} << 8) - {8'd0, r_v};

    always_comb begin
        case (r_ch)
            2'd0:    w_e = i_color_exp[47:32];
            2'd1:    w_e = i_color_exp[31:16];
            default: w_e = i_color_exp[15:0];
        endcase
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_rgb     = r_rgb;
    assign o_escaped = r_esc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it       <= i_res.iter;
                        r_pend_esc <= i_res.escaped;
                        if (i_res.escaped) begin
                            r_lx    <= i_res.sq;
                            r_lp    <= 7'd127;
                            r_frac  <= '0;
                            r_call  <= 2'd0;
                            r_state <= S_NORM;
                        end else begin
                            r_chan[0] <= '0;
                            r_chan[1] <= '0;
                            r_chan[2] <= '0;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_NORM: begin
                    if (r_lx == '0) begin
                        r_lp    <= '0;
                        r_frac  <= '0;
                        r_state <= S_LDONE;
                    end else if (r_lx[127]) begin
                        r_m     <= r_lx[127:96];
                        r_frac  <= '0;
                        r_k     <= 5'd31;
                        r_state <= S_LSQ;
                    end else if (r_lx[127:96] == 32'd0) begin
                        r_lx <= r_lx << 32;
                        r_lp <= r_lp - 7'd32;
                    end else begin
                        r_lx <= r_lx << 1;
                        r_lp <= r_lp - 7'd1;
                    end
                end
                S_LSQ: begin
                    r_mul   <= 64'(r_m) * 64'(r_m);
                    r_state <= S_LADJ;
                end
                S_LADJ: begin
                    if (r_mul[63]) begin
                        r_m         <= r_mul[63:32];
                        r_frac[r_k] <= 1'b1;
                    end else begin
                        r_m <= r_mul[62:31];
                    end
                    if (r_k == 5'd0) begin
                        r_state <= S_LDONE;
                    end else begin
                        r_k     <= r_k - 5'd1;
                        r_state <= S_LSQ;
                    end
                end
                S_LDONE: begin
                    case (r_call)
                        2'd0: begin
                            r_lx    <= {89'd0, w_lres - F_OFS};
                            r_lp    <= 7'd127;
                            r_call  <= 2'd1;
                            r_state <= S_NORM;
                        end
                        2'd1: begin
                            r_num   <= {4'd0, r_it, 32'd0} - {4'd0, i_start_iter, 32'd0}
                                     - {13'd0, w_lres} + {13'd0, LG_LC2};
                            r_state <= S_T;
                        end
                        default: begin
                            r_lt    <= w_lres;
                            r_ch    <= 2'd0;
                            r_state <= S_CH;
                        end
                    endcase
                end
                S_T: begin
                    if (w_d == 17'd0) begin
                        r_t     <= r_num[51] ? 33'd0 : (33'd1 << 32);
                        r_state <= S_TCHK;
                    end else if (r_num != '0 && (r_num[51] != w_d[16])) begin
                        r_t     <= '0;
                        r_state <= S_TCHK;
                    end else begin
                        r_q     <= w_anum[49:0];
                        r_rem   <= '0;
                        r_ad    <= w_d[16] ? (17'd0 - w_d) : w_d;
                        r_dcnt  <= 6'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_tmp >= {1'b0, r_ad}) begin
                        r_rem <= 17'(w_tmp - {1'b0, r_ad});
                        r_q   <= {r_q[48:0], 1'b1};
                    end else begin
                        r_rem <= w_tmp[16:0];
                        r_q   <= {r_q[48:0], 1'b0};
                    end
                    if (r_dcnt == 6'd49) begin
                        r_state <= S_TCHK;
                    end else begin
                        r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                S_TCHK: begin
                    if (r_dcnt == 6'd49) begin
                        r_dcnt <= '0;
                        r_t    <= (r_q > 50'h1_0000_0000) ? (33'd1 << 32) : r_q[32:0];
                    end else if (r_t[32] || r_t == '0) begin
                        r_ch    <= 2'd0;
                        r_state <= S_CH;
                    end else begin
                        r_lx    <= {95'd0, r_t};
                        r_lp    <= 7'd127;
                        r_call  <= 2'd2;
                        r_state <= S_NORM;
                    end
                end
                S_CH: begin
                    if (r_t[32] || w_e == 16'd0) begin
                        r_v     <= 32'd1 << 30;
                        r_state <= S_CHV;
                    end else if (r_t == '0) begin
                        r_v     <= '0;
                        r_state <= S_CHV;
                    end else begin
                        r_prod  <= 54'(w_e) * 54'(w_negl);
                        r_state <= S_CH2;
                    end
                end
                S_CH2: begin
                    if (w_f == 32'd0) begin
                        r_v     <= (w_n > 10'd30) ? 32'd0 : ((32'd1 << 30) >> w_n);
                        r_state <= S_CHV;
                    end else if (w_n >= 10'd30) begin
                        r_v     <= '0;
                        r_state <= S_CHV;
                    end else begin
                        r_g     <= 32'd0 - w_f;
                        r_acc   <= 32'd1 << 30;
                        r_k     <= 5'd31;
                        r_sh    <= w_n[4:0] + 5'd1;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    r_mul   <= 64'(r_acc) * 64'(ROOT_TAB[r_k*32 +: 32]);
                    r_state <= S_EXPA;
                end
                S_EXPA: begin
                    r_acc <= w_acc_new;
                    if (r_k == 5'd0) begin
                        r_v     <= w_acc_new >> r_sh;
                        r_state <= S_CHV;
                    end else begin
                        r_k     <= r_k - 5'd1;
                        r_state <= S_EXP;
                    end
                end
                S_CHV: begin
                    r_chan[r_ch] <= w_v255[37:30];
                    if (r_ch == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_CH;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_rgb   <= {r_chan[2], r_chan[1], r_chan[0]};
                        r_esc   <= r_pend_esc;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ test/mscp_pixel_checker.sv @@
`timescale 1ns / 1ps
module mscp_pixel_checker
    import mscp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int           COORD_FRAC = 60;
    localparam logic [127:0] ESC_THR    = {64'd0, ESCAPE_LIMIT} << COORD_FRAC;
    localparam logic [63:0]  Q32_ONE    = 64'h1_0000_0000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       escaped;
    } pixel_t;

    logic [63:0] cen_re, cen_im;
    logic [62:0] step;
    logic [15:0] start_it, end_it, max_it;
    logic [47:0] gamma;
    pixel_t      pixel_queue[$];
    int          fails;

    function automatic logic [127:0] umul_frac(input logic [127:0] a, input logic [127:0] b);
        logic [255:0] p;
        p = {128'd0, a} * {128'd0, b};
        return p[COORD_FRAC +: 128];
    endfunction

    function automatic logic [63:0] log2_q32(input logic [127:0] x);
        int          p;
        logic [63:0] m;
        logic [31:0] fr;
        if (x == '0) return 64'd0;
        p = 0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) p = i;
        end
        if (p >= 31) m = 64'(x >> (p - 31));
        else m = 64'(x << (31 - p));
        m  = m & 64'hFFFF_FFFF;
        fr = '0;
        for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m[32]) begin
                m     = m >> 1;
                fr[i] = 1'b1;
            end
        end
        return {25'd0, 7'(p), fr};
    endfunction

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(g / 2^32) in Q2.30 as a product of repeated square roots of two.
    function automatic logic [63:0] pow2_frac(input logic [63:0] g);
        logic [63:0] acc, root;
        acc  = 64'd1 << 30;
        root = 64'd2 << 30;
        for (int k = 31; k >= 0; k--) begin
            root = isqrt_u64(root << 30);
            if (g[k]) acc = (acc * root) >> 30;
        end
        return acc;
    endfunction

    function automatic logic [7:0] gamma_channel(input logic [63:0] t, input logic [15:0] e);
        logic [63:0] l, m, n, f, v;
        if (t >= Q32_ONE || e == 0) return 8'd255;
        if (t == 0) return 8'd0;
        l = log2_q32(128'(t)) - (64'd32 << 32);
        m = (64'(e) * (-l)) >> 12;
        n = m >> 32;
        f = m & 64'hFFFF_FFFF;
        if (f == 0) begin
            if (n > 30) return 8'd0;
            v = (64'd1 << 30) >> n;
        end else begin
            if (n + 1 > 30) return 8'd0;
            v = pow2_frac(Q32_ONE - f) >> (n + 1);
        end
        return 8'((v * 255) >> 30);
    endfunction

    function automatic logic [127:0] pixel_coord(input logic [63:0] centre, input logic [11:0] off);
        logic [12:0]  mag;
        logic [127:0] prod;
        mag  = off[11] ? 13'h1000 - {1'b0, off} : {1'b0, off};
        prod = 128'(mag) * 128'(step);
        if (off[11]) prod = -prod;
        return {{64{centre[63]}}, centre} + prod;
    endfunction

    function automatic pixel_t predict_pixel(input logic [11:0] ox, input logic [11:0] oy);
        logic [127:0]       cr, ci, zr, zi, sq, ar, ai, r2, i2, x;
        logic [63:0]        lz, lc, term, mu, t, an, ad;
        logic signed [63:0] num, d;
        int unsigned        it;
        logic               esc;
        pixel_t             px;
        cr  = pixel_coord(cen_re, ox);
        ci  = pixel_coord(cen_im, oy);
        zr  = '0;
        zi  = '0;
        sq  = '0;
        esc = 1'b0;
        for (it = 0; it < max_it; it++) begin
            ar = zr[127] ? -zr : zr;
            ai = zi[127] ? -zi : zi;
            r2 = umul_frac(ar, ar);
            i2 = umul_frac(ai, ai);
            sq = r2 + i2;
            if (sq >= ESC_THR) begin
                esc = 1'b1;
                break;
            end
            x = umul_frac(ar, ai);
            x = x + x;
            if (zr[127] != zi[127]) x = -x;
            zr = r2 - i2 + cr;
            zi = x + ci;
        end
        px = '0;
        if (!esc) return px;
        // Smooth count: subtract log2 of the normalized log of |z|^2.
        lz   = log2_q32(sq) - (64'(COORD_FRAC) << 32);
        lc   = log2_q32(128'(ESCAPE_LIMIT));
        term = log2_q32(128'(lz)) - log2_q32(128'(lc));
        mu   = (64'(it) << 32) - term;
        num  = $signed(mu - (64'(start_it) << 32));
        d    = $signed(64'(end_it)) - $signed(64'(start_it));
        if (d == 0) begin
            t = (num >= 0) ? Q32_ONE : 64'd0;
        end else if (num != 0 && ((num < 0) != (d < 0))) begin
            t = '0;
        end else begin
            an = (num < 0) ? 64'(-num) : 64'(num);
            ad = (d < 0) ? 64'(-d) : 64'(d);
            t  = an / ad;
            if (t > Q32_ONE) t = Q32_ONE;
        end
        px.red     = gamma_channel(t, gamma[47:32]);
        px.green   = gamma_channel(t, gamma[31:16]);
        px.blue    = gamma_channel(t, gamma[15:0]);
        px.escaped = 1'b1;
        return px;
    endfunction

    always @(posedge i_clk) begin : watch
        pixel_t want, got;
        if (!i_rst_n) begin
            cen_re   = '0;
            cen_im   = '0;
            step     = '0;
            start_it = 16'd0;
            end_it   = 16'd256;
            max_it   = 16'd256;
            gamma    = 48'd68723691520;
            pixel_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_RE:  cen_re   = i_cfg_data;
                    CFG_CENTER_IM:  cen_im   = i_cfg_data;
                    CFG_PIXEL_STEP: step     = i_cfg_data[62:0];
                    CFG_START_ITER: start_it = i_cfg_data[15:0];
                    CFG_END_ITER:   end_it   = i_cfg_data[15:0];
                    CFG_MAX_ITER:   max_it   = i_cfg_data[15:0];
                    CFG_COLOR_EXP:  gamma    = i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pixel_queue.push_back(predict_pixel(s_tdata[11:0], s_tdata[23:12]));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser};
                if (pixel_queue.size() == 0) begin
                    if (fails < 10) $display("unexpected result word r=%0d g=%0d b=%0d esc=%0b",
                                             got.red, got.green, got.blue, got.escaped);
                    fails++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want.red != got.red || want.green != got.green ||
                        want.blue != got.blue || want.escaped != got.escaped) begin
                        if (fails < 10) begin
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d esc=%0b",
                                     want.red, want.green, want.blue, want.escaped);
                            $display("                actual   r=%0d g=%0d b=%0d esc=%0b",
                                     got.red, got.green, got.blue, got.escaped);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pixel_queue.size();
    end

endmodule

@@ test/mandelbrot_smooth_color_pixel_top_test.sv @@
`timescale 1ns / 1ps
module mandelbrot_smooth_color_pixel_top_test;
    import mscp_pkg::*;

    // Q4.60 helpers for building views.
    localparam logic [63:0] HALF     = 64'd1 << 59;
    localparam int          QUIET_MAX = 60000;
    localparam logic [2:0]  REG_ORDER [7] = '{CFG_CENTER_RE, CFG_CENTER_IM, CFG_PIXEL_STEP,
                                              CFG_START_ITER, CFG_END_ITER, CFG_MAX_ITER,
                                              CFG_COLOR_EXP};

    logic        i_clk, i_rst_n;
    logic        s_tvalid, s_tready;
    logic [23:0] s_tdata;       // offset_x[11:0], offset_y[23:12]
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;       // red[7:0], green[15:8], blue[23:16]
    logic        m_tuser;       // escaped
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    int fail_count, words_pending;
    bit calm;                   // no idling on either side while set
    int hold_request, hold_left, quiet;

    mandelbrot_smooth_color_pixel_top u_top (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    mscp_pixel_checker u_checker (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The sink accepts at random, or always while calm is set, except during a requested
    // hold-off, which it counts itself so that the block backs up and has to stall its input.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_MAX) begin
            $display("mandelbrot_smooth_color_pixel_top_test: done, errors");
            $finish;
        end
    end

    // Offer one pixel word, sometimes after a short gap, and wait until it is taken.
    task automatic offer_pixel(input logic [11:0] ox, input logic [11:0] oy);
        if (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {oy, ox};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted pixel has come back.
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes all seven registers; the block is idle whenever this is called.
    task automatic load_view(input logic [63:0] cre, input logic [63:0] cim,
                             input logic [63:0] pstep, input logic [15:0] first,
                             input logic [15:0] last, input logic [15:0] limit,
                             input logic [47:0] gam);
        logic [63:0] vals [7];
        vals = '{cre, cim, pstep, 64'(first), 64'(last), 64'(limit), 64'(gam)};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_ORDER[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_exponent();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h3000));
    endfunction

    initial begin
        logic [15:0] first, last, limit;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_CENTER_RE;
        i_cfg_data   = '0;
        calm         = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        quiet        = 0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset view: zero step and centre, so every pixel sits at the origin and runs
        // the full default limit.
        offer_pixel(12'd0, 12'd0);
        offer_pixel(12'd5, -12'sd3);
        drain_pixels();

        // Classic view, offsets at the corners and the axes; one exponent of one,
        // one of zero and the largest one.
        load_view(-HALF, 64'd0, 64'd1 << 51, 16'd0, 16'd64, 16'd64,
                  {16'h1000, 16'h0000, 16'hFFFF});
        offer_pixel(12'h800, 12'h800);
        offer_pixel(12'h7FF, 12'h7FF);
        offer_pixel(12'h800, 12'h7FF);
        offer_pixel(12'h7FF, 12'h800);
        offer_pixel(12'd0, 12'd0);
        offer_pixel(12'd1, 12'hFFF);
        offer_pixel(-12'sd600, 12'd300);
        offer_pixel(-12'sd300, 12'd0);
        drain_pixels();

        // Equal start and end counts.
        load_view(-HALF, 64'd0, 64'd1 << 51, 16'd12, 16'd12, 16'd64,
                  {16'h2000, 16'h0800, 16'h1000});
        offer_pixel(12'd600, 12'd100);
        offer_pixel(-12'sd900, -12'sd900);
        offer_pixel(-12'sd80, 12'd40);
        drain_pixels();

        // Reversed start and end.
        load_view(-HALF, 64'd0, 64'd1 << 51, 16'd40, 16'd3, 16'd48,
                  {16'h1800, 16'h0400, 16'h1000});
        offer_pixel(12'd700, 12'd0);
        offer_pixel(-12'sd1200, 12'd200);
        offer_pixel(12'd100, 12'd700);
        drain_pixels();

        // A window that early escapes fall below (negative t) and late ones pass (full t).
        load_view(-HALF, 64'd0, 64'd1 << 51, 16'd30, 16'd31, 16'd64,
                  {16'h1000, 16'h3000, 16'h0100});
        offer_pixel(12'd2000, 12'd2000);
        offer_pixel(-12'sd160, 12'd260);
        offer_pixel(-12'sd500, 12'd300);
        drain_pixels();

        // Register extremes: centre far outside on the positive real side, so with
        // nonnegative column offsets every orbit escapes within a few passes.
        load_view(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  16'd0, 16'hFFFF, 16'hFFFF, 48'($urandom) ^ (48'($urandom) << 16));
        offer_pixel(12'd0, 12'h800);
        offer_pixel(12'h7FF, 12'h7FF);
        offer_pixel(12'd5, 12'd0);
        offer_pixel(12'd0, 12'd0);
        drain_pixels();

        // Random views. Phase 0 and 1 use the smallest limits (all points inside);
        // phase 0 also holds the sink off long enough to back the block up.
        for (int phase = 0; phase < 6; phase++) begin
            first = 16'($urandom_range(0, 6));
            case (phase)
                0:       limit = 16'd1;
                1:       limit = 16'd2;
                default: limit = 16'($urandom_range(8, 40));
            endcase
            case (phase)
                3:       last = first;
                4:       last = 16'($urandom_range(0, 2));
                default: last = first + 16'($urandom_range(4, 40));
            endcase
            load_view((64'($urandom_range(0, 1023)) << 50) - HALF - HALF,
                      (64'($urandom_range(0, 1023)) << 50) - HALF,
                      64'($urandom_range(1, 8)) << 49, first, last, limit,
                      {pick_exponent(), pick_exponent(), pick_exponent()});
            calm = (phase == 2);
            if (phase == 0) hold_request = 3000;
            for (int n = 0; n < 140; n++) begin
                offer_pixel(12'($urandom), 12'($urandom));
                // Let the block run dry once in the middle of a stream.
                if (phase == 5 && n == 70) drain_pixels();
            end
            drain_pixels();
            calm = 1'b0;
        end

        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("mandelbrot_smooth_color_pixel_top_test: done, clean");
        end else begin
            $display("mandelbrot_smooth_color_pixel_top_test: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mscp_pkg.sv
rtl/mscp_front.sv
rtl/mscp_queue.sv
rtl/mscp_orbit.sv
rtl/mscp_color.sv
rtl/mandelbrot_smooth_color_pixel_top.sv
test/mscp_pixel_checker.sv
test/mandelbrot_smooth_color_pixel_top_test.sv
